### sv/hrd_pkg.sv
// ----------------------------------------------------------------------------
// HTTP response dechunker package
// Shared constants, state codes, result type and byte classifiers.
// ----------------------------------------------------------------------------
`default_nettype none

package hrd_pkg;

    localparam int CHUNK_SIZE_BITS = 28;
    localparam int HDR_CNT_BITS    = 15;

    localparam logic [HDR_CNT_BITS-1:0] HEADER_LIMIT_RESET = 15'd10240;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_CLOSE = 1'b1;

    // Response phase, one-hot.
    typedef enum logic [3:0] {
        PH_HEADER     = 4'b0001,
        PH_BODY_FIRST = 4'b0010,
        PH_BODY       = 4'b0100,
        PH_OVERFLOW   = 4'b1000
    } t_phase;

    // Chunk parser phase, one-hot.
    typedef enum logic [3:0] {
        CK_SKIP  = 4'b0001,
        CK_RUN   = 4'b0010,
        CK_SKIP2 = 4'b0100,
        CK_COPY  = 4'b1000
    } t_chunk;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_BODY     = 2'd1,
        KIND_END      = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    function automatic logic is_alnum(input logic [7:0] b);
        logic res;
        res = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
              ((b >= 8'h61) && (b <= 8'h7A));
        return res;
    endfunction

    // Hex digit value, or 16 when the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd16;
        if ((b >= 8'h30) && (b <= 8'h39)) begin
            v = b - 8'h30;
        end else if ((b >= 8'h61) && (b <= 8'h66)) begin
            v = b - 8'h57;
        end else if ((b >= 8'h41) && (b <= 8'h46)) begin
            v = b - 8'h37;
        end
        return v[4:0];
    endfunction

    function automatic logic [7:0] terminator_char(input logic [1:0] idx);
        logic [7:0] c;
        c = idx[0] ? CHAR_LF : CHAR_CR;
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/hrd_core.sv
// ----------------------------------------------------------------------------
// HTTP response dechunker core
// Per-response state and the combinational decode of one request.
// ----------------------------------------------------------------------------
`default_nettype none

module hrd_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_step,
    input  wire logic                             i_req_type,
    input  wire logic [7:0]                       i_data_byte,
    input  wire logic                             i_chunked_body,
    input  wire logic [hrd_pkg::HDR_CNT_BITS-1:0] i_header_limit,
    output hrd_pkg::t_result                      o_result
);

    localparam int W = hrd_pkg::CHUNK_SIZE_BITS;

    hrd_pkg::t_phase                   r_phase,    n_phase;
    hrd_pkg::t_chunk                   r_chunk,    n_chunk;
    logic [1:0]                        r_matched,  n_matched;
    logic [hrd_pkg::HDR_CNT_BITS-1:0]  r_seen,     n_seen;
    logic [W-1:0]                      r_len,      n_len;
    logic                              r_stopped,  n_stopped;
    logic                              r_latched,  n_latched;
    logic                              r_ended,    n_ended;
    hrd_pkg::t_result                  res;

    logic       alnum;
    logic [4:0] hv;
    logic       hex_ok;
    logic [W-1:0] len_dec;

    assign alnum   = hrd_pkg::is_alnum(i_data_byte);
    assign hv      = hrd_pkg::hex_value(i_data_byte);
    assign hex_ok  = !hv[4];
    assign len_dec = r_len - W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_chunk   = r_chunk;
        n_matched = r_matched;
        n_seen    = r_seen;
        n_len     = r_len;
        n_stopped = r_stopped;
        n_latched = r_latched;
        n_ended   = r_ended;
        res.valid = 1'b0;
        res.kind  = hrd_pkg::KIND_HEADER;
        res.data  = 8'd0;
        res.last  = 1'b0;

        if (i_req_type == hrd_pkg::REQ_CLOSE) begin
            if (((r_phase == hrd_pkg::PH_BODY_FIRST) || (r_phase == hrd_pkg::PH_BODY)) &&
                !r_ended) begin
                res.valid = 1'b1;
                res.kind  = hrd_pkg::KIND_END;
            end
            n_phase   = hrd_pkg::PH_HEADER;
            n_chunk   = hrd_pkg::CK_SKIP;
            n_matched = 2'd0;
            n_seen    = '0;
            n_len     = '0;
            n_stopped = 1'b0;
            n_latched = 1'b0;
            n_ended   = 1'b0;
        end else begin
            case (r_phase)
                hrd_pkg::PH_HEADER: begin
                    res.valid = 1'b1;
                    if (r_seen >= i_header_limit) begin
                        n_phase  = hrd_pkg::PH_OVERFLOW;
                        res.kind = hrd_pkg::KIND_OVERFLOW;
                    end else begin
                        n_seen   = r_seen + 1'b1;
                        res.kind = hrd_pkg::KIND_HEADER;
                        res.data = i_data_byte;
                        if (i_data_byte == hrd_pkg::terminator_char(r_matched)) begin
                            if (r_matched == 2'd3) begin
                                n_matched = 2'd0;
                                n_phase   = hrd_pkg::PH_BODY_FIRST;
                                res.last  = 1'b1;
                            end else begin
                                n_matched = r_matched + 2'd1;
                            end
                        end else begin
                            // A broken match may still start a new terminator.
                            n_matched = (i_data_byte == hrd_pkg::CHAR_CR) ? 2'd1 : 2'd0;
                        end
                    end
                end
                hrd_pkg::PH_BODY_FIRST, hrd_pkg::PH_BODY: begin
                    n_phase = hrd_pkg::PH_BODY;
                    if (r_phase == hrd_pkg::PH_BODY_FIRST) begin
                        n_latched = i_chunked_body;
                    end
                    if (!r_ended) begin
                        if (!n_latched) begin
                            res.valid = 1'b1;
                            res.kind  = hrd_pkg::KIND_BODY;
                            res.data  = i_data_byte;
                        end else begin
                            case (r_chunk)
                                hrd_pkg::CK_SKIP: begin
                                    if (alnum) begin
                                        n_chunk   = hrd_pkg::CK_RUN;
                                        n_len     = hex_ok ? W'(hv[3:0]) : '0;
                                        n_stopped = !hex_ok;
                                    end
                                end
                                hrd_pkg::CK_RUN: begin
                                    if (alnum) begin
                                        if (!r_stopped) begin
                                            if (hex_ok) begin
                                                n_len = {r_len[W-5:0], hv[3:0]};
                                            end else begin
                                                n_stopped = 1'b1;
                                            end
                                        end
                                    end else if (r_len == '0) begin
                                        n_ended   = 1'b1;
                                        n_chunk   = hrd_pkg::CK_SKIP;
                                        res.valid = 1'b1;
                                        res.kind  = hrd_pkg::KIND_END;
                                    end else begin
                                        n_chunk = hrd_pkg::CK_SKIP2;
                                    end
                                end
                                hrd_pkg::CK_SKIP2: begin
                                    n_chunk = hrd_pkg::CK_COPY;
                                end
                                hrd_pkg::CK_COPY: begin
                                    n_len     = len_dec;
                                    if (len_dec == '0) begin
                                        n_chunk = hrd_pkg::CK_SKIP;
                                    end
                                    res.valid = 1'b1;
                                    res.kind  = hrd_pkg::KIND_BODY;
                                    res.data  = i_data_byte;
                                end
                                default: begin
                                    n_chunk = hrd_pkg::CK_SKIP;
                                end
                            endcase
                        end
                    end
                end
                hrd_pkg::PH_OVERFLOW: begin
                    n_phase = hrd_pkg::PH_OVERFLOW;
                end
                default: begin
                    n_phase = hrd_pkg::PH_HEADER;
                end
            endcase
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= hrd_pkg::PH_HEADER;
            r_chunk   <= hrd_pkg::CK_SKIP;
            r_matched <= 2'd0;
            r_seen    <= '0;
            r_len     <= '0;
            r_stopped <= 1'b0;
            r_latched <= 1'b0;
            r_ended   <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_chunk   <= n_chunk;
            r_matched <= n_matched;
            r_seen    <= n_seen;
            r_len     <= n_len;
            r_stopped <= n_stopped;
            r_latched <= n_latched;
            r_ended   <= n_ended;
        end
    end

endmodule

`default_nettype wire

### sv/http_response_dechunker.sv
// ----------------------------------------------------------------------------
// HTTP response dechunker
// Splits a response stream into header bytes and decoded body payload.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel (i_in_valid / o_in_stall) is one
// received byte or a connection close. The output channel (o_out_valid /
// i_out_stall) carries zero or one result per request: a header byte, a body
// byte, a body end or a header overflow, in request order.
// A request lands in the input register when it is accepted, and its result
// is written to the output register when the decoder steps it. Throughput is
// one request per cycle while the receiver does not stall; the per-response
// state updates in a single pass of the decoder between the two registers.
// When the receiver stalls with a result waiting, the input register still
// fills, and o_in_stall rises only once both registers hold work.
// Reset clears both registers and all per-response state, and loads the
// header limit with 10240. The limit is written through i_cfg_we; the user
// must write it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_dechunker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [hrd_pkg::HDR_CNT_BITS-1:0] i_cfg_data,
    input  wire logic                             i_in_valid,
    output      logic                             o_in_stall,
    input  wire logic                             i_req_type,
    input  wire logic [7:0]                       i_data_byte,
    input  wire logic                             i_chunked_body,
    output      logic                             o_out_valid,
    input  wire logic                             i_out_stall,
    output      logic [1:0]                       o_out_kind,
    output      logic [7:0]                       o_out_byte,
    output      logic                             o_is_last
);

    logic [hrd_pkg::HDR_CNT_BITS-1:0] r_header_limit;

    logic       r_in_valid;
    logic       r_req_type;
    logic [7:0] r_data_byte;
    logic       r_chunked_body;

    logic       r_out_valid;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_byte;
    logic       r_is_last;

    logic             out_free;
    logic             step;
    hrd_pkg::t_result result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    hrd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_req_type     (r_req_type),
        .i_data_byte    (r_data_byte),
        .i_chunked_body (r_chunked_body),
        .i_header_limit (r_header_limit),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_limit <= hrd_pkg::HEADER_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_header_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_req_type     <= i_req_type;
            r_data_byte    <= i_data_byte;
            r_chunked_body <= i_chunked_body;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && result.valid) begin
            r_out_kind <= result.kind;
            r_out_byte <= result.data;
            r_is_last  <= result.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_is_last   = r_is_last;

`ifndef SYNTHESIS
    a_last_on_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_last) |-> (o_out_kind == hrd_pkg::KIND_HEADER))
        else $error("last marker on a result that is not a header byte");

    a_no_byte_on_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_out_kind == hrd_pkg::KIND_END) ||
                         (o_out_kind == hrd_pkg::KIND_OVERFLOW)))
        |-> (o_out_byte == 8'd0))
        else $error("end or overflow result carries a byte");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while the pipeline can move");

    a_held_request_processed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_in_stall) |=> r_in_valid)
        else $error("stalled request lost from the input register");

    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

### test/http_response_dechunker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP response dechunker testbench
// Streams header, plain-body and chunked-body responses through the block,
// with random idle and stall patterns, and checks every result in order.
// ----------------------------------------------------------------------------

module testbench;
    import hrd_pkg::*;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_REQUESTS = 275;
    localparam int NUM_PHASES     = 6;
    localparam int HOLD_CYCLES    = 80;
    localparam int TIMEOUT_NS     = 2_000_000;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_RESULT,
        CHK_NONE
    } t_check;

    typedef struct packed {
        logic       req;
        logic [7:0] data;
        logic       chunked;
    } t_request;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_request  rq;
        t_check    chk;
        t_out_item res;
    } t_dir_row;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic [HDR_CNT_BITS-1:0] i_cfg_data     = '0;
    logic                    i_in_valid     = 1'b0;
    logic                    i_req_type     = 1'b0;
    logic [7:0]              i_data_byte    = 8'h00;
    logic                    i_chunked_body = 1'b0;
    logic                    i_out_stall    = 1'b0;
    wire                     o_in_stall;
    wire                     o_out_valid;
    wire  [1:0]              o_out_kind;
    wire  [7:0]              o_out_byte;
    wire                     o_is_last;

    http_response_dechunker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_data_byte    (i_data_byte),
        .i_chunked_body (i_chunked_body),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_kind     (o_out_kind),
        .o_out_byte     (o_out_byte),
        .o_is_last      (o_is_last)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Decoder model state.
    logic [HDR_CNT_BITS-1:0]    hdr_limit;
    t_phase                     resp_ph;
    logic [2:0]                 crlf_cnt;
    logic [HDR_CNT_BITS-1:0]    hdr_cnt;
    t_chunk                     ck_ph;
    logic [CHUNK_SIZE_BITS-1:0] ck_len;
    logic                       digits_done;
    logic                       chunked_q;
    logic                       body_done;

    t_out_item pending_results[$];
    t_request  stim_q[$];

    int error_count     = 0;
    int results_checked = 0;
    int requests_sent   = 0;
    int kind_seen[4]    = '{0, 0, 0, 0};
    int tx_pct          = 0;
    int rx_pct          = 0;
    int hold_len        = 0;
    int hold_seq        = 0;
    int hold_seen       = 0;
    int hold_left       = 0;

    t_dir_row dir_rows [26];

    task automatic clear_response_state();
        resp_ph     = PH_HEADER;
        crlf_cnt    = 3'd0;
        hdr_cnt     = '0;
        ck_ph       = CK_SKIP;
        ck_len      = '0;
        digits_done = 1'b0;
        chunked_q   = 1'b0;
        body_done   = 1'b0;
    endtask

    // Returns {alphanumeric, hex value}, the value being 16 for a non-hex byte.
    function automatic logic [5:0] char_info(input logic [7:0] b);
        logic [7:0] lc;
        lc = b | 8'h20;
        if (b >= 8'h30 && b <= 8'h39) begin
            return {1'b1, 1'b0, b[3:0]};
        end else if (lc >= 8'h61 && lc <= 8'h7A) begin
            if (lc <= 8'h66) begin
                return {1'b1, 5'(lc - 8'h57)};
            end
            return {1'b1, 5'd16};
        end
        return {1'b0, 5'd16};
    endfunction

    task automatic decode_request(input t_request rq, output logic has_out,
                                  output t_out_item res);
        logic [5:0] info;
        has_out  = 1'b0;
        res.kind = KIND_HEADER;
        res.data = 8'h00;
        res.last = 1'b0;
        info     = char_info(rq.data);
        if (rq.req == REQ_CLOSE) begin
            if ((resp_ph == PH_BODY_FIRST || resp_ph == PH_BODY) && !body_done) begin
                has_out  = 1'b1;
                res.kind = KIND_END;
            end
            clear_response_state();
        end else begin
            case (resp_ph)
                PH_HEADER: begin
                    if (hdr_cnt >= hdr_limit) begin
                        resp_ph  = PH_OVERFLOW;
                        has_out  = 1'b1;
                        res.kind = KIND_OVERFLOW;
                    end else begin
                        hdr_cnt = hdr_cnt + 1'b1;
                        // A byte that breaks the match may itself open a new one.
                        if (rq.data == (crlf_cnt[0] ? CHAR_LF : CHAR_CR)) begin
                            crlf_cnt = crlf_cnt + 3'd1;
                        end else begin
                            crlf_cnt = (rq.data == CHAR_CR) ? 3'd1 : 3'd0;
                        end
                        has_out  = 1'b1;
                        res.data = rq.data;
                        if (crlf_cnt == 3'd4) begin
                            crlf_cnt = 3'd0;
                            resp_ph  = PH_BODY_FIRST;
                            res.last = 1'b1;
                        end
                    end
                end
                PH_BODY_FIRST, PH_BODY: begin
                    if (resp_ph == PH_BODY_FIRST) begin
                        chunked_q = rq.chunked;
                        resp_ph   = PH_BODY;
                    end
                    if (body_done) begin
                        has_out = 1'b0;
                    end else if (!chunked_q) begin
                        has_out  = 1'b1;
                        res.kind = KIND_BODY;
                        res.data = rq.data;
                    end else begin
                        case (ck_ph)
                            CK_SKIP: begin
                                if (info[5]) begin
                                    ck_len      = '0;
                                    digits_done = info[4];
                                    if (!info[4]) begin
                                        ck_len = {{(CHUNK_SIZE_BITS-4){1'b0}}, info[3:0]};
                                    end
                                    ck_ph = CK_RUN;
                                end
                            end
                            CK_RUN: begin
                                if (info[5]) begin
                                    // Letters and digits after a non-hex letter are ignored.
                                    if (!digits_done) begin
                                        if (info[4]) begin
                                            digits_done = 1'b1;
                                        end else begin
                                            ck_len = {ck_len[CHUNK_SIZE_BITS-5:0], info[3:0]};
                                        end
                                    end
                                end else if (ck_len == '0) begin
                                    body_done = 1'b1;
                                    ck_ph     = CK_SKIP;
                                    has_out   = 1'b1;
                                    res.kind  = KIND_END;
                                end else begin
                                    ck_ph = CK_SKIP2;
                                end
                            end
                            CK_SKIP2: begin
                                ck_ph = CK_COPY;
                            end
                            default: begin
                                ck_len = ck_len - 1'b1;
                                if (ck_len == '0) begin
                                    ck_ph = CK_SKIP;
                                end
                                has_out  = 1'b1;
                                res.kind = KIND_BODY;
                                res.data = rq.data;
                            end
                        endcase
                    end
                end
                default: begin
                    has_out = 1'b0;
                end
            endcase
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] base;
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end
        base = ($urandom_range(1) != 0) ? 8'h61 : 8'h41;
        return base + 8'(v - 4'd10);
    endfunction

    function automatic logic [7:0] rand_separator();
        logic [7:0] b;
        logic [5:0] info;
        do begin
            b    = 8'($urandom);
            info = char_info(b);
        end while (info[5]);
        return b;
    endfunction

    task automatic push_request(input logic req, input logic [7:0] data, input logic ck);
        t_request rq;
        rq.req     = req;
        rq.data    = data;
        rq.chunked = ck;
        stim_q.push_back(rq);
    endtask

    task automatic send_request(input t_request rq);
        while ($urandom_range(99) < tx_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= rq.req;
        i_data_byte    <= rq.data;
        i_chunked_body <= rq.chunked;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        requests_sent++;
    endtask

    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= HDR_CNT_BITS'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        hdr_limit   = HDR_CNT_BITS'(value);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_left   <= hold_len;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result kind %0d byte %02h last %0b with no request pending",
                         $time, o_out_kind, o_out_byte, o_is_last);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                kind_seen[int'(want.kind)]++;
                if (o_out_kind !== want.kind) begin
                    error_count++;
                    $display("%0t: out_kind expected %0d, got %0d", $time, want.kind, o_out_kind);
                end
                if (o_out_byte !== want.data) begin
                    error_count++;
                    $display("%0t: out_byte expected %02h, got %02h", $time, want.data, o_out_byte);
                end
                if (o_is_last !== want.last) begin
                    error_count++;
                    $display("%0t: is_last expected %0b, got %0b", $time, want.last, o_is_last);
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_request  rq;
        t_out_item res;
        logic      has_out;
        logic      flag;
        logic [7:0] b;
        int        limit_set[NUM_PHASES];
        int        tx_set[NUM_PHASES];
        int        rx_set[NUM_PHASES];
        int        style;
        int        size;
        int        cut;
        int        sent;

        limit_set = '{16, 16384, 16, 16, 16, 10240};
        limit_set[2] = $urandom_range(16, 64);
        limit_set[4] = $urandom_range(16, 16384);
        tx_set = '{0, 58, 0, 25, 0, 25};
        rx_set = '{0, 0, 58, 25, 0, 25};

        // Header with a repeated CR, then a chunk whose size run is cut by a
        // non-hex letter, a high separator, a zero size and a dropped byte.
        // The second response has a plain body ended by the close.
        dir_rows = '{
            '{'{REQ_CLOSE, 8'h00, 1'b0}, CHK_NONE,   '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  "H",   1'b1}, CHK_RESULT, '{KIND_HEADER, "H",   1'b0}},
            '{'{REQ_BYTE,  CHAR_CR, 1'b0}, CHK_RESULT, '{KIND_HEADER, CHAR_CR, 1'b0}},
            '{'{REQ_BYTE,  CHAR_CR, 1'b0}, CHK_RESULT, '{KIND_HEADER, CHAR_CR, 1'b0}},
            '{'{REQ_BYTE,  CHAR_LF, 1'b0}, CHK_RESULT, '{KIND_HEADER, CHAR_LF, 1'b0}},
            '{'{REQ_BYTE,  CHAR_CR, 1'b0}, CHK_MODEL,  '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  CHAR_LF, 1'b0}, CHK_RESULT, '{KIND_HEADER, CHAR_LF, 1'b1}},
            '{'{REQ_BYTE,  " ",   1'b1}, CHK_NONE,   '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  "1",   1'b0}, CHK_NONE,   '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  "z",   1'b0}, CHK_NONE,   '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  "5",   1'b0}, CHK_NONE,   '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  ";",   1'b0}, CHK_NONE,   '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  CHAR_LF, 1'b0}, CHK_NONE,   '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  8'hFF, 1'b0}, CHK_RESULT, '{KIND_BODY,   8'hFF, 1'b0}},
            '{'{REQ_BYTE,  8'h80, 1'b0}, CHK_NONE,   '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  "0",   1'b0}, CHK_NONE,   '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  CHAR_CR, 1'b0}, CHK_RESULT, '{KIND_END,    8'h00, 1'b0}},
            '{'{REQ_BYTE,  "A",   1'b0}, CHK_NONE,   '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_CLOSE, 8'hFF, 1'b1}, CHK_NONE,   '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  CHAR_CR, 1'b1}, CHK_MODEL,  '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  CHAR_LF, 1'b1}, CHK_MODEL,  '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  CHAR_CR, 1'b1}, CHK_MODEL,  '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_BYTE,  CHAR_LF, 1'b1}, CHK_RESULT, '{KIND_HEADER, CHAR_LF, 1'b1}},
            '{'{REQ_BYTE,  8'h00, 1'b0}, CHK_RESULT, '{KIND_BODY,   8'h00, 1'b0}},
            '{'{REQ_BYTE,  8'hFF, 1'b1}, CHK_MODEL,  '{KIND_HEADER, 8'h00, 1'b0}},
            '{'{REQ_CLOSE, 8'h00, 1'b0}, CHK_RESULT, '{KIND_END,    8'h00, 1'b0}}
        };

        hdr_limit = HEADER_LIMIT_RESET;
        clear_response_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].rq);
            decode_request(dir_rows[i].rq, has_out, res);
            case (dir_rows[i].chk)
                CHK_MODEL:  if (has_out) pending_results.push_back(res);
                CHK_RESULT: pending_results.push_back(dir_rows[i].res);
                default:    has_out = 1'b0;
            endcase
        end
        settle_pipeline();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_limit(limit_set[p]);
            tx_pct  = tx_set[p];
            rx_pct <= rx_set[p];
            if (p == 4) begin
                // Long receiver hold-off while the sender keeps requesting.
                hold_len <= HOLD_CYCLES;
                hold_seq <= hold_seq + 1;
            end
            sent = 0;
            while (sent < PHASE_REQUESTS) begin
                style = $urandom_range(99);
                if (style < 8) begin
                    repeat ($urandom_range(4, 16)) begin
                        push_request(($urandom_range(9) == 0) ? REQ_CLOSE : REQ_BYTE,
                                     8'($urandom), 1'($urandom));
                    end
                end else begin
                    flag = ($urandom_range(99) < 60);
                    repeat ($urandom_range(0, 24)) begin
                        if ($urandom_range(3) == 0) begin
                            b = ($urandom_range(1) != 0) ? CHAR_CR : CHAR_LF;
                        end else begin
                            b = 8'($urandom);
                        end
                        push_request(REQ_BYTE, b, 1'($urandom));
                    end
                    // A few responses close while still in the header.
                    if (style >= 14) begin
                        push_request(REQ_BYTE, CHAR_CR, 1'($urandom));
                        push_request(REQ_BYTE, CHAR_LF, 1'($urandom));
                        push_request(REQ_BYTE, CHAR_CR, 1'($urandom));
                        push_request(REQ_BYTE, CHAR_LF, 1'($urandom));
                        if (!flag) begin
                            repeat ($urandom_range(0, 30)) push_request(REQ_BYTE, 8'($urandom), flag);
                        end else begin
                            repeat ($urandom_range(0, 4)) begin
                                repeat ($urandom_range(0, 2)) push_request(REQ_BYTE, rand_separator(), flag);
                                size = $urandom_range(1, 20);
                                if ($urandom_range(99) < 15) begin
                                    // Extra leading digits fall off the top of the size.
                                    repeat ($urandom_range(1, 2)) push_request(REQ_BYTE, hex_char(4'($urandom)), flag);
                                    for (int k = 6; k >= 0; k--) begin
                                        push_request(REQ_BYTE, hex_char(4'(size >> (4 * k))), flag);
                                    end
                                end else begin
                                    repeat ($urandom_range(0, 2)) push_request(REQ_BYTE, "0", flag);
                                    if (size > 15) push_request(REQ_BYTE, hex_char(4'(size >> 4)), flag);
                                    push_request(REQ_BYTE, hex_char(4'(size)), flag);
                                end
                                if ($urandom_range(99) < 15) begin
                                    push_request(REQ_BYTE, 8'($urandom_range(8'h67, 8'h7A)) & 8'hDF |
                                                 (($urandom_range(1) != 0) ? 8'h20 : 8'h00), flag);
                                    repeat ($urandom_range(0, 3)) push_request(REQ_BYTE, hex_char(4'($urandom)), flag);
                                end
                                push_request(REQ_BYTE, rand_separator(), flag);
                                push_request(REQ_BYTE, ($urandom_range(3) == 0) ? 8'($urandom) : CHAR_LF, flag);
                                repeat (size) push_request(REQ_BYTE, 8'($urandom), flag);
                                if ($urandom_range(3) != 0) begin
                                    push_request(REQ_BYTE, CHAR_CR, flag);
                                    push_request(REQ_BYTE, CHAR_LF, flag);
                                end
                            end
                            if ($urandom_range(99) < 80) begin
                                if ($urandom_range(3) == 0) begin
                                    push_request(REQ_BYTE, "z", flag);
                                end else begin
                                    repeat ($urandom_range(1, 3)) push_request(REQ_BYTE, "0", flag);
                                end
                                push_request(REQ_BYTE, rand_separator(), flag);
                                repeat ($urandom_range(0, 3)) push_request(REQ_BYTE, 8'($urandom), flag);
                            end
                        end
                    end
                    push_request(REQ_CLOSE, 8'($urandom), 1'($urandom));
                    if ($urandom_range(99) < 10) begin
                        cut = $urandom_range(1, stim_q.size());
                        while (stim_q.size() > cut) void'(stim_q.pop_back());
                        push_request(REQ_CLOSE, 8'($urandom), 1'($urandom));
                    end
                end

                while (stim_q.size() != 0) begin
                    rq = stim_q.pop_front();
                    send_request(rq);
                    decode_request(rq, has_out, res);
                    if (has_out) pending_results.push_back(res);
                    sent++;
                    // Sender pause until the output has caught up.
                    if (p == 3 && sent == PHASE_REQUESTS / 2) settle_pipeline();
                end
            end
            settle_pipeline();
        end

        $display("Checked %0d results (%0d header, %0d body, %0d end, %0d overflow) from %0d requests.",
                 results_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
                 requests_sent);
        $display("Covered header limits 16 to 16384 under idle, stall and hold-off traffic.");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
